### src/tbs_pkg.sv
// Shared types and constants for the tempo beat scheduler.
`timescale 1ns / 1ps
package tbs_pkg;

   localparam int BEAT_W   = 32;
   localparam int TIME_W   = 64;
   localparam int PERIOD_W = 36;
   localparam int ACT_W    = 2;
   localparam int TR_W     = 2;
   localparam int LEAD_W   = 8;
   localparam int LOOK_W   = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [BEAT_W-1:0]   BEAT_MAX       = '1;
   localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 36'd500000000;

   // actions
   localparam logic [ACT_W-1:0] ACT_TICK      = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TEMPO     = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TRANSPORT = 2'd2;
   localparam logic [ACT_W-1:0] ACT_START     = 2'd3;

   // transport states
   localparam logic [TR_W-1:0] TR_STOPPED   = 2'd0;
   localparam logic [TR_W-1:0] TR_SCHEDULED = 2'd1;
   localparam logic [TR_W-1:0] TR_PLAYING   = 2'd2;
   localparam logic [TR_W-1:0] TR_INVALID   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEAD_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOOKAHEAD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLIDE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_PER  = 2'd3;

   // datapath operations
   typedef logic [3:0] tbs_op_type;
   localparam tbs_op_type OP_NONE      = 4'd0;
   localparam tbs_op_type OP_LOAD      = 4'd1;
   localparam tbs_op_type OP_START     = 4'd2;
   localparam tbs_op_type OP_DIV       = 4'd3;
   localparam tbs_op_type OP_APPLY     = 4'd4;
   localparam tbs_op_type OP_MUL_EDGE  = 4'd5;
   localparam tbs_op_type OP_EDGE      = 4'd6;
   localparam tbs_op_type OP_MUL_CUR   = 4'd7;
   localparam tbs_op_type OP_ACT_TEMPO = 4'd8;
   localparam tbs_op_type OP_ACT_TR    = 4'd9;
   localparam tbs_op_type OP_MUL_ENTRY = 4'd10;
   localparam tbs_op_type OP_EMIT      = 4'd11;
   localparam tbs_op_type OP_REJECT    = 4'd12;

   typedef struct packed {
      logic div_done;
      logic reject;
      logic tempo_imm;
      logic out_free;
      logic ent_last;
   } tbs_status_type;

   function automatic logic [PERIOD_W-1:0] safe_period(input logic [PERIOD_W-1:0] p);
      safe_period = (p == '0) ? DEFAULT_PERIOD : p;
   endfunction

endpackage

### src/tbs_if.sv
// Channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface tbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] now_time;
   logic [31:0] target_beat;
   logic [35:0] new_period;
   logic [1:0]  new_transport;
   modport source (output valid, action, now_time, target_beat, new_period, new_transport,
                   input ready);
   modport sink (input valid, action, now_time, target_beat, new_period, new_transport,
                 output ready);
endinterface

interface tbs_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] now_beat;
   logic [1:0]  active_transport;
   logic [35:0] active_period;
   logic [31:0] entry_beat;
   logic [63:0] entry_time;
   logic        wake_target;
   logic        last;
   modport source (output valid, status, now_beat, active_transport, active_period,
                   entry_beat, entry_time, wake_target, last, input ready);
   modport sink (input valid, status, now_beat, active_transport, active_period,
                 entry_beat, entry_time, wake_target, last, output ready);
endinterface

interface tbs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [35:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/tbs_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tbs_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tbs_pkg::TIME_W-1:0]   dividend,
   input  logic [tbs_pkg::PERIOD_W-1:0] divisor,
   output logic                       done,
   output logic [tbs_pkg::TIME_W-1:0]   quotient
);
   import tbs_pkg::*;

   localparam int CNT_W = $clog2(TIME_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

   logic [PERIOD_W-1:0] rem_ff, rem_in, div_ff;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [PERIOD_W:0]   shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_W-1]};
      diff    = shifted - {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[PERIOD_W]) begin
            rem_in = diff[PERIOD_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[PERIOD_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) div_ff <= divisor;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### src/tbs_datapath.sv
// Beat clock state, registers, multiplier pipeline and response register.
`timescale 1ns / 1ps
module tbs_datapath #(
   parameter int LOOKAHEAD_MAX = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tbs_pkg::tbs_op_type          op,
   output tbs_pkg::tbs_status_type      status,
   input  logic                         csr_valid,
   input  logic [tbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbs_pkg::PERIOD_W-1:0] csr_data,
   input  logic [tbs_pkg::ACT_W-1:0]    req_action,
   input  logic [tbs_pkg::TIME_W-1:0]   req_now_time,
   input  logic [tbs_pkg::BEAT_W-1:0]   req_target_beat,
   input  logic [tbs_pkg::PERIOD_W-1:0] req_new_period,
   input  logic [tbs_pkg::TR_W-1:0]     req_new_transport,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic                         rsp_status,
   output logic [tbs_pkg::BEAT_W-1:0]   rsp_now_beat,
   output logic [tbs_pkg::TR_W-1:0]     rsp_active_transport,
   output logic [tbs_pkg::PERIOD_W-1:0] rsp_active_period,
   output logic [tbs_pkg::BEAT_W-1:0]   rsp_entry_beat,
   output logic [tbs_pkg::TIME_W-1:0]   rsp_entry_time,
   output logic                         rsp_wake_target,
   output logic                         rsp_last
);
   import tbs_pkg::*;

   localparam int IW = (LOOKAHEAD_MAX > 1) ? $clog2(LOOKAHEAD_MAX) : 1;
   localparam logic [6:0] LM7 = 7'(LOOKAHEAD_MAX);

   // registers
   logic [LEAD_W-1:0]   lead_ff;
   logic [LOOK_W-1:0]   lah_ff, slide_ff;
   logic [PERIOD_W-1:0] init_ff;
   // latched request
   logic [ACT_W-1:0]    act_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [BEAT_W-1:0]   tgt_ff;
   logic [PERIOD_W-1:0] nper_ff;
   logic [TR_W-1:0]     ntr_ff;
   // beat clock state
   logic [TIME_W-1:0]   at_ff;
   logic [BEAT_W-1:0]   ab_ff;
   logic [PERIOD_W-1:0] pn_ff;
   logic                tp_ff;
   logic [BEAT_W-1:0]   tpb_ff;
   logic [PERIOD_W-1:0] tpp_ff;
   logic [TR_W-1:0]     tn_ff;
   logic                trp_ff;
   logic [BEAT_W-1:0]   trpb_ff;
   logic [TR_W-1:0]     trps_ff;
   // work registers
   logic [BEAT_W-1:0]   cur_ff;
   logic [TIME_W-1:0]   edge_ff;
   logic [IW-1:0]       idx_ff;
   // multiplier pipeline
   logic [BEAT_W-1:0]   mk_ff;
   logic [PERIOD_W-1:0] mp_ff;
   logic [TIME_W-1:0]   mb_ff, mb2_ff, plo_ff, mres_ff;
   logic [31:0]         phi_ff;
   logic [BEAT_W-1:0]   mk_in;
   logic [PERIOD_W-1:0] mp_in;
   logic [TIME_W-1:0]   mb_in;
   // response register
   logic                rv_ff;

   logic                div_done;
   logic [TIME_W-1:0]   quo;
   logic [TIME_W-1:0]   dvd;
   logic [BEAT_W:0]     beat_sum, ent_sum, lead_sum;
   logic [BEAT_W-1:0]   cur_calc, b_ent, b_sel;
   logic [6:0]          look, slide, idx7;
   logic                out_free;

   assign dvd = (now_ff > at_ff) ? now_ff - at_ff : '0;

   tbs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (op == OP_DIV),
      .dividend (dvd),
      .divisor  (safe_period(pn_ff)),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      beat_sum = {1'b0, ab_ff} + {1'b0, quo[BEAT_W-1:0]};
      if (quo[TIME_W-1:BEAT_W] != '0 || beat_sum[BEAT_W]) cur_calc = BEAT_MAX;
      else cur_calc = beat_sum[BEAT_W-1:0];
   end

   always_comb begin
      ent_sum = {1'b0, cur_ff} + (BEAT_W+1)'(idx_ff) + 1'b1;
      b_ent   = ent_sum[BEAT_W] ? BEAT_MAX : ent_sum[BEAT_W-1:0];
      b_sel   = (op == OP_MUL_CUR) ? cur_ff : b_ent;
   end

   always_comb begin
      look  = ({2'b0, lah_ff} == 7'd0) ? 7'd1 :
              (({2'b0, lah_ff} > LM7) ? LM7 : {2'b0, lah_ff});
      slide = ({2'b0, slide_ff} == 7'd0) ? 7'd1 :
              (({2'b0, slide_ff} > look) ? look : {2'b0, slide_ff});
      idx7  = 7'(idx_ff);
   end

   // multiplier operands
   always_comb begin
      if (op == OP_MUL_EDGE) begin
         mk_in = (tpb_ff > ab_ff) ? tpb_ff - ab_ff : '0;
         mp_in = pn_ff;
         mb_in = at_ff;
      end else if (tp_ff && b_sel > tpb_ff) begin
         mk_in = b_sel - tpb_ff;
         mp_in = tpp_ff;
         mb_in = edge_ff;
      end else begin
         mk_in = (b_sel > ab_ff) ? b_sel - ab_ff : '0;
         mp_in = pn_ff;
         mb_in = at_ff;
      end
   end

   assign lead_sum = {1'b0, cur_ff} + (BEAT_W+1)'(lead_ff);
   assign out_free = !rv_ff || rsp_ready;

   always_comb begin
      status.div_done  = div_done;
      status.reject    = ((act_ff == ACT_TEMPO) ? (nper_ff == '0) : (ntr_ff == TR_INVALID)) ||
                         (tn_ff != TR_STOPPED && {1'b0, tgt_ff} < lead_sum);
      status.tempo_imm = (act_ff == ACT_TEMPO) && (tgt_ff <= cur_ff);
      status.out_free  = out_free;
      status.ent_last  = (idx7 == look - 7'd1);
   end

   always_ff @(posedge clock) begin
      mk_ff   <= mk_in;
      mp_ff   <= mp_in;
      mb_ff   <= mb_in;
      plo_ff  <= TIME_W'(mk_ff * mp_ff[31:0]);
      phi_ff  <= 32'(mk_ff * mp_ff[PERIOD_W-1:32]);
      mb2_ff  <= mb_ff;
      mres_ff <= mb2_ff + plo_ff + {phi_ff, 32'h0};

      if (op == OP_LOAD) begin
         act_ff  <= req_action;
         now_ff  <= req_now_time;
         tgt_ff  <= req_target_beat;
         nper_ff <= req_new_period;
         ntr_ff  <= req_new_transport;
         idx_ff  <= '0;
      end
      if (div_done) cur_ff <= cur_calc;
      if (op == OP_EDGE || op == OP_ACT_TEMPO) edge_ff <= mres_ff;
      if (op == OP_EMIT) idx_ff <= idx_ff + 1'b1;

      if (op == OP_EMIT) begin
         rsp_status           <= 1'b0;
         rsp_now_beat         <= cur_ff;
         rsp_active_transport <= tn_ff;
         rsp_active_period    <= pn_ff;
         rsp_entry_beat       <= b_ent;
         rsp_entry_time       <= mres_ff;
         rsp_wake_target      <= (idx7 == slide - 7'd1);
         rsp_last             <= (idx7 == look - 7'd1);
      end else if (op == OP_REJECT) begin
         rsp_status           <= 1'b1;
         rsp_now_beat         <= cur_ff;
         rsp_active_transport <= tn_ff;
         rsp_active_period    <= pn_ff;
         rsp_entry_beat       <= '0;
         rsp_entry_time       <= '0;
         rsp_wake_target      <= 1'b0;
         rsp_last             <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= 8'd1;
         lah_ff   <= 5'd4;
         slide_ff <= 5'd1;
         init_ff  <= DEFAULT_PERIOD;
         at_ff    <= '0;
         ab_ff    <= '0;
         pn_ff    <= DEFAULT_PERIOD;
         tp_ff    <= 1'b0;
         tpb_ff   <= '0;
         tpp_ff   <= '0;
         tn_ff    <= TR_STOPPED;
         trp_ff   <= 1'b0;
         trpb_ff  <= '0;
         trps_ff  <= TR_STOPPED;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_LEAD_TIME: lead_ff  <= csr_data[LEAD_W-1:0];
               REG_LOOKAHEAD: lah_ff   <= csr_data[LOOK_W-1:0];
               REG_SLIDE:     slide_ff <= csr_data[LOOK_W-1:0];
               REG_INIT_PER:  init_ff  <= csr_data;
               default: ;
            endcase
         end

         if (op == OP_EMIT || op == OP_REJECT) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;

         if (op == OP_START) begin
            at_ff  <= now_ff;
            ab_ff  <= '0;
            pn_ff  <= safe_period(init_ff);
            tp_ff  <= 1'b0;
            trp_ff <= 1'b0;
         end

         if (op == OP_APPLY) begin
            if (act_ff == ACT_TEMPO) begin
               if (tgt_ff <= cur_ff) begin
                  ab_ff <= cur_ff;
                  at_ff <= mres_ff;
                  pn_ff <= nper_ff;
                  tp_ff <= 1'b0;
               end else begin
                  tp_ff  <= 1'b1;
                  tpb_ff <= tgt_ff;
                  tpp_ff <= nper_ff;
               end
            end else begin
               if (tgt_ff <= cur_ff) begin
                  tn_ff  <= ntr_ff;
                  trp_ff <= 1'b0;
               end else begin
                  trp_ff  <= 1'b1;
                  trpb_ff <= tgt_ff;
                  trps_ff <= ntr_ff;
               end
            end
         end

         // pending tempo falls due once the request time reaches its edge time
         if (op == OP_ACT_TEMPO && tp_ff && now_ff >= mres_ff) begin
            ab_ff <= tpb_ff;
            at_ff <= mres_ff;
            pn_ff <= safe_period(tpp_ff);
            tp_ff <= 1'b0;
         end

         if (op == OP_ACT_TR && trp_ff && cur_ff >= trpb_ff) begin
            tn_ff  <= trps_ff;
            trp_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rv_ff;
endmodule

### src/tbs_ctrl.sv
// Sequencer that walks the datapath through one request.
`timescale 1ns / 1ps
module tbs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [tbs_pkg::ACT_W-1:0] req_action,
   output logic                     req_ready,
   input  tbs_pkg::tbs_status_type  status,
   output tbs_pkg::tbs_op_type      op
);
   import tbs_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_START = 5'd1;
   localparam logic [4:0] S_DIV1  = 5'd2;
   localparam logic [4:0] S_DIV1W = 5'd3;
   localparam logic [4:0] S_DEC   = 5'd4;
   localparam logic [4:0] S_CE    = 5'd5;
   localparam logic [4:0] S_CEW1  = 5'd6;
   localparam logic [4:0] S_CEW2  = 5'd7;
   localparam logic [4:0] S_CES   = 5'd8;
   localparam logic [4:0] S_CT    = 5'd9;
   localparam logic [4:0] S_CTW1  = 5'd10;
   localparam logic [4:0] S_CTW2  = 5'd11;
   localparam logic [4:0] S_CTA   = 5'd12;
   localparam logic [4:0] S_AMUL  = 5'd13;
   localparam logic [4:0] S_AW1   = 5'd14;
   localparam logic [4:0] S_AW2   = 5'd15;
   localparam logic [4:0] S_ACT   = 5'd16;
   localparam logic [4:0] S_DIV2  = 5'd17;
   localparam logic [4:0] S_DIV2W = 5'd18;
   localparam logic [4:0] S_TR    = 5'd19;
   localparam logic [4:0] S_ENT   = 5'd20;
   localparam logic [4:0] S_EW1   = 5'd21;
   localparam logic [4:0] S_EW2   = 5'd22;
   localparam logic [4:0] S_EMIT  = 5'd23;
   localparam logic [4:0] S_REJ   = 5'd24;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = OP_LOAD;
               unique case (req_action)
                  ACT_START:                state_in = S_START;
                  ACT_TEMPO, ACT_TRANSPORT: state_in = S_DIV1;
                  default:                  state_in = S_AMUL;
               endcase
            end
         end
         S_START: begin
            op       = OP_START;
            state_in = S_AMUL;
         end
         S_DIV1: begin
            op       = OP_DIV;
            state_in = S_DIV1W;
         end
         S_DIV1W: if (status.div_done) state_in = S_DEC;
         S_DEC: begin
            priority if (status.reject) state_in = S_REJ;
            else if (status.tempo_imm) state_in = S_CE;
            else begin
               op       = OP_APPLY;
               state_in = S_AMUL;
            end
         end
         // immediate tempo: time of the current beat, through the pending edge
         S_CE: begin
            op       = OP_MUL_EDGE;
            state_in = S_CEW1;
         end
         S_CEW1: state_in = S_CEW2;
         S_CEW2: state_in = S_CES;
         S_CES: begin
            op       = OP_EDGE;
            state_in = S_CT;
         end
         S_CT: begin
            op       = OP_MUL_CUR;
            state_in = S_CTW1;
         end
         S_CTW1: state_in = S_CTW2;
         S_CTW2: state_in = S_CTA;
         S_CTA: begin
            op       = OP_APPLY;
            state_in = S_AMUL;
         end
         S_AMUL: begin
            op       = OP_MUL_EDGE;
            state_in = S_AW1;
         end
         S_AW1: state_in = S_AW2;
         S_AW2: state_in = S_ACT;
         S_ACT: begin
            op       = OP_ACT_TEMPO;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            op       = OP_DIV;
            state_in = S_DIV2W;
         end
         S_DIV2W: if (status.div_done) state_in = S_TR;
         S_TR: begin
            op       = OP_ACT_TR;
            state_in = S_ENT;
         end
         S_ENT: begin
            op       = OP_MUL_ENTRY;
            state_in = S_EW1;
         end
         S_EW1: state_in = S_EW2;
         S_EW2: state_in = S_EMIT;
         S_EMIT: begin
            if (status.out_free) begin
               op       = OP_EMIT;
               state_in = status.ent_last ? S_IDLE : S_ENT;
            end
         end
         S_REJ: begin
            if (status.out_free) begin
               op       = OP_REJECT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

### src/tempo_beat_scheduler_top.sv
// Top level of the tempo beat scheduler.
//
//   channel   direction  handshake      beat
//   csr_bus   in         valid/ready    register index and write data
//   req_bus   in         valid/ready    action, time, target beat, period, transport
//   rsp_bus   out        valid/ready    schedule entry or reject status
//
// A tick and a start each run the 64-step radix-2 divider once, an accepted change runs
// it twice and a rejected change once; each schedule entry passes the multiplier's
// operand, partial-product and result registers. An immediate tempo change adds two
// more multiplications, for the pending edge and for the current beat.
// Reset is synchronous; it sets the sequencer, the registers and the beat clock state.
// A stalled response holds the sequencer; a new request is taken while the final
// beat still waits in the response register.
`timescale 1ns / 1ps
module tempo_beat_scheduler_top #(
   parameter int LOOKAHEAD_MAX = 16
) (
   input  logic       clock,
   input  logic       reset,
   tbs_csr_if.sink    csr_bus,
   tbs_req_if.sink    req_bus,
   tbs_rsp_if.source  rsp_bus
);
   import tbs_pkg::*;

   tbs_op_type     op;
   tbs_status_type status;

   assign csr_bus.ready = 1'b1;

   tbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .status     (status),
      .op         (op)
   );

   tbs_datapath #(.LOOKAHEAD_MAX(LOOKAHEAD_MAX)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .op                   (op),
      .status               (status),
      .csr_valid            (csr_bus.valid),
      .csr_index            (csr_bus.index),
      .csr_data             (csr_bus.data),
      .req_action           (req_bus.action),
      .req_now_time         (req_bus.now_time),
      .req_target_beat      (req_bus.target_beat),
      .req_new_period       (req_bus.new_period),
      .req_new_transport    (req_bus.new_transport),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_status           (rsp_bus.status),
      .rsp_now_beat         (rsp_bus.now_beat),
      .rsp_active_transport (rsp_bus.active_transport),
      .rsp_active_period    (rsp_bus.active_period),
      .rsp_entry_beat       (rsp_bus.entry_beat),
      .rsp_entry_time       (rsp_bus.entry_time),
      .rsp_wake_target      (rsp_bus.wake_target),
      .rsp_last             (rsp_bus.last)
   );
endmodule

### tb/tempo_beat_scheduler_checker.sv
// Schedule predictor and response comparison for the tempo beat scheduler.
`timescale 1ns / 1ps
module tempo_beat_scheduler_checker #(
   parameter int LOOKAHEAD_MAX = 16
) (
   input  logic  clock,
   input  logic  reset,
   tbs_csr_if    csr_bus,
   tbs_req_if    req_bus,
   tbs_rsp_if    rsp_bus,
   output int    fail_count,
   output int    beats_pending
);
   import tbs_pkg::*;

   typedef struct {
      logic                status;
      logic [BEAT_W-1:0]   now_beat;
      logic [TR_W-1:0]     transport;
      logic [PERIOD_W-1:0] period;
      logic [BEAT_W-1:0]   entry_beat;
      logic [TIME_W-1:0]   entry_time;
      logic                wake;
      logic                last;
   } sched_entry_type;

   sched_entry_type sched_q[$];

   // register copies
   logic [LEAD_W-1:0]   lead_beats;
   logic [LOOK_W-1:0]   look_beats;
   logic [LOOK_W-1:0]   slide_beats;
   logic [PERIOD_W-1:0] init_period;

   // beat clock state
   logic [TIME_W-1:0]   anc_time;
   logic [63:0]         anc_beat;
   logic [PERIOD_W-1:0] cur_period;
   logic                tempo_pend;
   logic [63:0]         tempo_pend_beat;
   logic [PERIOD_W-1:0] tempo_pend_period;
   logic [TR_W-1:0]     cur_transport;
   logic                tr_pend;
   logic [63:0]         tr_pend_beat;
   logic [TR_W-1:0]     tr_pend_state;

   function automatic logic [PERIOD_W-1:0] nonzero_period(logic [PERIOD_W-1:0] p);
      return (p == '0) ? DEFAULT_PERIOD : p;
   endfunction

   function automatic logic [63:0] beat_of_time(logic [63:0] now);
      logic [63:0] q;
      logic [63:0] b;
      if (now <= anc_time) return anc_beat;
      q = (now - anc_time) / {28'd0, nonzero_period(cur_period)};
      if (q > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
      b = anc_beat + q;
      return (b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : b;
   endfunction

   function automatic logic [63:0] beats_past(logic [63:0] b, logic [63:0] base);
      return (b > base) ? b - base : 64'd0;
   endfunction

   function automatic logic [63:0] tempo_edge_time();
      logic [63:0] prod;
      prod = beats_past(tempo_pend_beat, anc_beat) * {28'd0, cur_period};
      return anc_time + prod;
   endfunction

   function automatic logic [63:0] time_of(logic [63:0] b);
      logic [63:0] prod;
      if (tempo_pend && b > tempo_pend_beat) begin
         prod = (b - tempo_pend_beat) * {28'd0, tempo_pend_period};
         return tempo_edge_time() + prod;
      end
      prod = beats_past(b, anc_beat) * {28'd0, cur_period};
      return anc_time + prod;
   endfunction

   task automatic queue_beat(sched_entry_type e);
      sched_q = {sched_q, e};
   endtask

   task automatic clear_state();
      anc_time = '0; anc_beat = '0; cur_period = nonzero_period(init_period);
      tempo_pend = 0; tempo_pend_beat = '0; tempo_pend_period = '0;
      cur_transport = TR_STOPPED; tr_pend = 0; tr_pend_beat = '0;
      tr_pend_state = TR_STOPPED;
   endtask

   task automatic predict_schedule(logic [ACT_W-1:0] act, logic [63:0] now,
                                   logic [63:0] target, logic [PERIOD_W-1:0] nper,
                                   logic [TR_W-1:0] ntr);
      logic [63:0] cur;
      logic [63:0] t;
      logic [63:0] b;
      int look;
      int slide;
      logic refuse;
      sched_entry_type e;
      refuse = 0;
      if (act == ACT_START) begin
         anc_time = now; anc_beat = '0; cur_period = nonzero_period(init_period);
         tempo_pend = 0; tr_pend = 0;
      end else if (act == ACT_TEMPO || act == ACT_TRANSPORT) begin
         cur = beat_of_time(now);
         if (act == ACT_TEMPO ? nper == '0 : ntr == TR_INVALID) refuse = 1;
         else if (cur_transport != TR_STOPPED && target < cur + {56'd0, lead_beats})
            refuse = 1;
         if (refuse) begin
            e.status = 1; e.now_beat = cur[31:0]; e.transport = cur_transport;
            e.period = cur_period; e.entry_beat = '0; e.entry_time = '0;
            e.wake = 0; e.last = 1;
            queue_beat(e);
            return;
         end
         if (act == ACT_TEMPO) begin
            if (target <= cur) begin
               t = time_of(cur);
               anc_beat = cur; anc_time = t; cur_period = nper; tempo_pend = 0;
            end else begin
               tempo_pend = 1; tempo_pend_beat = target; tempo_pend_period = nper;
            end
         end else begin
            if (target <= cur) begin
               cur_transport = ntr; tr_pend = 0;
            end else begin
               tr_pend = 1; tr_pend_beat = target; tr_pend_state = ntr;
            end
         end
      end
      // due changes
      if (tempo_pend) begin
         t = tempo_edge_time();
         if (now >= t) begin
            anc_beat = tempo_pend_beat; anc_time = t;
            cur_period = nonzero_period(tempo_pend_period); tempo_pend = 0;
         end
      end
      if (tr_pend && beat_of_time(now) >= tr_pend_beat) begin
         cur_transport = tr_pend_state; tr_pend = 0;
      end
      cur = beat_of_time(now);
      look = int'(look_beats);
      if (look < 1) look = 1;
      if (look > LOOKAHEAD_MAX) look = LOOKAHEAD_MAX;
      slide = int'(slide_beats);
      if (slide < 1) slide = 1;
      if (slide > look) slide = look;
      for (int i = 0; i < look; i++) begin
         b = cur + 1 + i;
         if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
         e.status = 0; e.now_beat = cur[31:0]; e.transport = cur_transport;
         e.period = cur_period; e.entry_beat = b[31:0]; e.entry_time = time_of(b);
         e.wake = (i == slide - 1); e.last = (i == look - 1);
         queue_beat(e);
      end
   endtask

   task automatic report(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("%t mismatch %s: expected %0d, actual %0d", $realtime, what, want, got);
   endtask

   initial begin
      fail_count = 0;
      beats_pending = 0;
   end

   always @(posedge clock) begin
      sched_entry_type e;
      if (reset) begin
         lead_beats = 8'd1; look_beats = 5'd4; slide_beats = 5'd1;
         init_period = DEFAULT_PERIOD;
         clear_state();
         sched_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_LEAD_TIME: lead_beats  = csr_bus.data[LEAD_W-1:0];
               REG_LOOKAHEAD: look_beats  = csr_bus.data[LOOK_W-1:0];
               REG_SLIDE:     slide_beats = csr_bus.data[LOOK_W-1:0];
               REG_INIT_PER:  init_period = csr_bus.data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sched_q.size() == 0) begin
               report("unexpected beat", 0, {63'd0, rsp_bus.last});
            end else begin
               e = sched_q.pop_front();
               if (rsp_bus.status !== e.status) report("status", e.status, rsp_bus.status);
               if (rsp_bus.now_beat !== e.now_beat)
                  report("now_beat", e.now_beat, rsp_bus.now_beat);
               if (rsp_bus.active_transport !== e.transport)
                  report("active_transport", e.transport, rsp_bus.active_transport);
               if (rsp_bus.active_period !== e.period)
                  report("active_period", e.period, rsp_bus.active_period);
               if (rsp_bus.entry_beat !== e.entry_beat)
                  report("entry_beat", e.entry_beat, rsp_bus.entry_beat);
               if (rsp_bus.entry_time !== e.entry_time)
                  report("entry_time", e.entry_time, rsp_bus.entry_time);
               if (rsp_bus.wake_target !== e.wake)
                  report("wake_target", e.wake, rsp_bus.wake_target);
               if (rsp_bus.last !== e.last) report("last", e.last, rsp_bus.last);
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_schedule(req_bus.action, req_bus.now_time, {32'd0, req_bus.target_beat},
                             req_bus.new_period, req_bus.new_transport);
      end
      beats_pending <= sched_q.size();
   end

endmodule

### tb/tempo_beat_scheduler_top_tb.sv
// Stimulus and verdict for the tempo beat scheduler.
`timescale 1ns / 1ps
module tempo_beat_scheduler_top_tb;
   import tbs_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   beats_pending;

   tbs_csr_if csr_bus ();
   tbs_req_if req_bus ();
   tbs_rsp_if rsp_bus ();

   tempo_beat_scheduler_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tempo_beat_scheduler_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_bus       (csr_bus),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .beats_pending (beats_pending)
   );

   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // receiver stall pattern, swapped per phase
   logic [15:0] stall_pat;
   int unsigned stall_pos = 0;
   always @(posedge clock) begin
      stall_pos <= stall_pos + 1;
      rsp_bus.ready <= stall_pat[stall_pos % 16];
   end

   logic [63:0] song_time;   // running clock for well-formed traffic
   logic [63:0] beat_guess;
   int unsigned per_guess;
   int burst_left;

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [35:0] val);
      csr_bus.valid <= 1; csr_bus.index <= idx; csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 0;
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] lead, logic [4:0] look, logic [4:0] slide,
                            logic [35:0] per);
      drain();
      write_reg(REG_LEAD_TIME, {28'd0, lead});
      write_reg(REG_LOOKAHEAD, {31'd0, look});
      write_reg(REG_SLIDE, {31'd0, slide});
      write_reg(REG_INIT_PER, per);
      per_guess = (per == '0 || per > 36'd100000) ? 32'd1000 : 32'(per);
   endtask

   // valid stays high across back-to-back beats; lowered only for a gap
   task automatic send(logic [1:0] act, logic [63:0] now, logic [31:0] tgt,
                       logic [35:0] per, logic [1:0] tr);
      req_bus.valid <= 1; req_bus.action <= act; req_bus.now_time <= now;
      req_bus.target_beat <= tgt; req_bus.new_period <= per; req_bus.new_transport <= tr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 0;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end
      end
   endtask

   task automatic random_item();
      int pick;
      logic [1:0] act;
      logic [31:0] tgt;
      logic [35:0] per;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         send(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
              {4'($urandom_range(0, 15)), $urandom}, 2'($urandom_range(0, 3)));
         return;
      end
      song_time += 64'($urandom_range(0, 3 * per_guess));
      beat_guess = song_time / 64'(per_guess);
      if (pick < 38) act = ACT_TICK;
      else if (pick < 64) act = ACT_TEMPO;
      else if (pick < 90) act = ACT_TRANSPORT;
      else act = ACT_START;
      if (act == ACT_START) begin
         song_time = 64'($urandom_range(0, 1000));
         beat_guess = 0;
      end
      tgt = beat_guess[31:0] + $urandom_range(0, 10);
      tgt = (tgt > 3) ? tgt - $urandom_range(0, 3) : tgt;
      per = ($urandom_range(0, 19) == 0) ? 36'd0 : 36'($urandom_range(200, 3000));
      send(act, song_time, tgt, per, ($urandom_range(0, 15) == 0) ? TR_INVALID
           : 2'($urandom_range(0, 2)));
   endtask

   initial begin
      reset = 1;
      stall_pat = '1;
      csr_bus.valid = 0; csr_bus.index = '0; csr_bus.data = '0;
      req_bus.valid = 0; req_bus.action = ACT_TICK; req_bus.now_time = '0;
      req_bus.target_beat = '0; req_bus.new_period = '0; req_bus.new_transport = '0;
      burst_left = 0; song_time = 0; beat_guess = 0; per_guess = 1000;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings first
      send(ACT_TICK, 64'd0, 0, 0, TR_STOPPED);
      send(ACT_TICK, 64'd1_250_000_000, 0, 0, TR_STOPPED);
      send(ACT_TEMPO, 64'd1_300_000_000, 0, 36'd0, TR_STOPPED);          // invalid tempo
      send(ACT_TRANSPORT, 64'd1_300_000_000, 0, 0, TR_INVALID);          // invalid state
      send(ACT_TRANSPORT, 64'd1_400_000_000, 2, 0, TR_PLAYING);          // immediate
      send(ACT_TEMPO, 64'd1_500_000_000, 1, 36'd250_000_000, TR_STOPPED); // too close
      send(ACT_TEMPO, 64'd1_600_000_000, 6, 36'd250_000_000, TR_STOPPED); // pending
      send(ACT_TICK, 64'd3_100_000_000, 0, 0, TR_STOPPED);                // due
      send(ACT_TRANSPORT, 64'd3_200_000_000, 20, 0, TR_SCHEDULED);
      send(ACT_TICK, 64'd9_000_000_000, 0, 0, TR_STOPPED);
      send(ACT_START, 64'd10_000_000_000, 0, 0, TR_STOPPED);
      send(ACT_TICK, 64'd5, 0, 0, TR_STOPPED);                            // before anchor
      send(ACT_TRANSPORT, '1, '1, '1, TR_STOPPED);
      send(ACT_TICK, '1, '1, '1, TR_PLAYING);                            // saturation

      configure(8'd0, 5'd16, 5'd16, 36'd1);
      stall_pat = 16'hA5A5;
      send(ACT_START, 64'hFFFF_FFFF_FFFF_FFF0, 0, 0, TR_STOPPED);
      send(ACT_TICK, 64'd20, 0, 0, TR_STOPPED);                           // time wrap
      send(ACT_TRANSPORT, 64'h8000_0000_0000_0000, 3, 0, TR_PLAYING);
      send(ACT_TEMPO, 64'h8000_0000_0000_0001, 0, 36'hF_FFFF_FFFF, TR_STOPPED);
      send(ACT_TICK, '1, 0, 0, TR_STOPPED);

      configure(8'd255, 5'd0, 5'd0, 36'd0);                              // zero period
      stall_pat = 16'h0F0F;
      send(ACT_START, 64'd0, 0, 0, TR_STOPPED);
      send(ACT_TEMPO, 64'd100, 100, 36'd60_000_000_000, TR_STOPPED);
      send(ACT_TEMPO, 64'd100, 300, 36'd1000, TR_STOPPED);

      configure(8'd2, 5'd31, 5'd31, 36'd60_000_000_000);
      send(ACT_START, 64'd0, 0, 0, TR_STOPPED);
      send(ACT_TICK, 64'd180_000_000_000, 0, 0, TR_STOPPED);

      // random phases
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: configure(8'd1, 5'd4, 5'd1, 36'd1000);
            1: configure(8'd0, 5'd16, 5'd9, 36'd700);
            2: configure(8'd3, 5'd1, 5'd1, 36'd2000);
            3: configure(8'd255, 5'd8, 5'd16, 36'd1500);
            4: configure(8'd2, 5'd0, 5'd0, 36'd0);
            5: configure(8'($urandom_range(0, 4)), 5'($urandom_range(1, 16)),
                         5'($urandom_range(1, 16)), 36'($urandom_range(300, 3000)));
            default: configure(8'd1, 5'd31, 5'd31, 36'd900);
         endcase
         // at least one ready slot per pattern so the receiver never locks up
         stall_pat = (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         song_time = 0; beat_guess = 0;
         send(ACT_START, 64'd0, 0, 0, TR_STOPPED);
         repeat (42) random_item();
      end

      drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
